FILE: sv/mra_pkg.sv
// Shared types and constants for the mark/release arena allocator.
package mra_pkg;

   // Fixed field widths
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 16;
   localparam int ELEM_W      = 16;
   localparam int SEGMENT_W   = 4;
   localparam int OFFSET_W    = 25;
   localparam int STATUS_W    = 2;
   localparam int CAP_W       = 25;
   localparam int BIG_FROM_W  = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 25;
   // count times rounded element size always fits in 32 bits
   localparam int REQ_W       = 32;

   // Defaults for the top-level parameters
   localparam int MAX_SEGMENTS_DEFAULT      = 16;
   localparam int MAX_SEGMENT_BYTES_DEFAULT = 16777216;

   localparam int ALIGN_BYTES = 4;
   localparam int QUEUE_DEPTH = 2;

   // Register reset values
   localparam logic [CAP_W-1:0]      SMALL_BYTES_RESET = CAP_W'(524288);
   localparam logic [CAP_W-1:0]      BIG_BYTES_RESET   = CAP_W'(1048576);
   localparam logic [BIG_FROM_W-1:0] BIG_FROM_RESET    = BIG_FROM_W'(8);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SMALL_BYTES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_BYTES   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_FROM    = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC     = 2'd0,
      MODE_SET_MARK  = 2'd1,
      MODE_RELEASE   = 2'd2,
      MODE_DROP_MARK = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_OPEN_SIZE,
      ST_OPEN_WRITE
   } back_state_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] elem_count;
      logic [ELEM_W-1:0]  elem_bytes;
   } req_type;

   typedef struct packed {
      logic [SEGMENT_W-1:0] segment;
      logic [OFFSET_W-1:0]  offset;
      logic [STATUS_W-1:0]  status;
   } rsp_type;

   // Classified transaction handed from front to back
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [REQ_W-1:0]  req_bytes;
   } job_type;

   typedef struct packed {
      logic [CAP_W-1:0]      small_bytes;
      logic [CAP_W-1:0]      big_bytes;
      logic [BIG_FROM_W-1:0] big_from;
   } cfg_type;

endpackage

FILE: sv/mark_release_arena_allocator_core.sv
// Allocate: IDLE, READ and CHECK to the result register when the first searched
//   segment fits, READ and CHECK again per further segment searched, plus OPEN_SIZE
//   and OPEN_WRITE when a new segment is opened. Set mark goes through READ and CHECK;
//   release and drop mark load the result from IDLE. One transaction at a time: the
//   next starts once the result is popped.
// Reset restores the config registers; segment 0 is written the cycle after, queue open.
module mark_release_arena_allocator_core #(
   parameter int MAX_SEGMENTS      = mra_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int MAX_SEGMENT_BYTES = mra_pkg::MAX_SEGMENT_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request transactions
   input  logic                               push,
   output logic                               full,
   input  mra_pkg::req_type                   req_data,
   // result transactions
   output logic                               empty,
   input  logic                               pop,
   output mra_pkg::rsp_type                   rsp_data,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mra_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mra_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mra_pkg::*;

   logic [CAP_W-1:0]      small_bytes_ff, small_bytes_in;
   logic [CAP_W-1:0]      big_bytes_ff, big_bytes_in;
   logic [BIG_FROM_W-1:0] big_from_ff, big_from_in;
   logic                  csr_write;
   cfg_type               cfg;

   logic    job_valid;
   logic    job_take;
   job_type job;

   // Configuration must only be written while idle; the block does not enforce this, so writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Unknown indexes fall through and leave all registers unchanged.
   always_comb begin
      small_bytes_in = small_bytes_ff;
      big_bytes_in   = big_bytes_ff;
      big_from_in    = big_from_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SMALL_BYTES: small_bytes_in = csr_data[CAP_W-1:0];
            CSR_BIG_BYTES:   big_bytes_in   = csr_data[CAP_W-1:0];
            CSR_BIG_FROM:    big_from_in    = csr_data[BIG_FROM_W-1:0];
            default:         small_bytes_in = small_bytes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_bytes_ff <= SMALL_BYTES_RESET;
         big_bytes_ff   <= BIG_BYTES_RESET;
         big_from_ff    <= BIG_FROM_RESET;
      end else begin
         small_bytes_ff <= small_bytes_in;
         big_bytes_ff   <= big_bytes_in;
         big_from_ff    <= big_from_in;
      end
   end

   always_comb begin
      cfg.small_bytes = small_bytes_ff;
      cfg.big_bytes   = big_bytes_ff;
      cfg.big_from    = big_from_ff;
   end

   // Front: request sizing (align, multiply) and a short transaction queue.
   mra_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_valid(job_valid),
      .job      (job),
      .job_take (job_take)
   );

   // Back: segment table walk, segment opening, mark/release, result register.
   mra_back #(
      .MAX_SEGMENTS     (MAX_SEGMENTS),
      .MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .job_valid(job_valid),
      .job      (job),
      .job_take (job_take),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

FILE: sv/mra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/mra_front.sv
// Front end: accepts transactions, sizes allocate requests, queues them for the back end.
module mra_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  mra_pkg::req_type req_data,
   output logic             job_valid,
   output mra_pkg::job_type job,
   input  logic             job_take
);
   import mra_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int RND_W = ELEM_W + 1;

   job_type          queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic                      accept;
   logic [RND_W-1:0]          rounded;
   logic [COUNT_W+RND_W-1:0]  product;
   job_type                   job_new;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign job_valid = (count_ff != '0);
   assign accept    = push && !full;

   // round element size up to the alignment, then scale by count
   assign rounded = (RND_W'(req_data.elem_bytes) + RND_W'(ALIGN_BYTES - 1))
                    & ~RND_W'(ALIGN_BYTES - 1);
   assign product = (COUNT_W+RND_W)'(req_data.elem_count) * (COUNT_W+RND_W)'(rounded);

   always_comb begin
      job_new.mode      = req_data.mode;
      job_new.req_bytes = product[REQ_W-1:0];
   end

   assign job = queue_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (accept) begin
         wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (job_take) begin
         rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (accept && !job_take) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && job_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wptr_ff] <= job_new;
      end
   end

endmodule

FILE: sv/mra_back.sv
// Back end: segment table, first-fit search, mark handling and result register.
module mra_back #(
   parameter int MAX_SEGMENTS      = mra_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int MAX_SEGMENT_BYTES = mra_pkg::MAX_SEGMENT_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  mra_pkg::cfg_type cfg,
   input  logic             job_valid,
   input  mra_pkg::job_type job,
   output logic             job_take,
   output logic             empty,
   input  logic             pop,
   output mra_pkg::rsp_type rsp_data
);
   import mra_pkg::*;

   localparam int SEG_W  = $clog2(MAX_SEGMENTS);
   localparam int BYTE_W = $clog2(MAX_SEGMENT_BYTES + 1);
   localparam int WORD_W = 2 * BYTE_W;
   localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(MAX_SEGMENTS - 1);
   localparam logic [BYTE_W-1:0] INIT_REM =
      (REQ_W'(SMALL_BYTES_RESET) > REQ_W'(MAX_SEGMENT_BYTES)) ?
      BYTE_W'(MAX_SEGMENT_BYTES) : BYTE_W'(SMALL_BYTES_RESET);

   function automatic logic [BYTE_W-1:0] cap_bytes(input logic [CAP_W-1:0] v);
      logic [REQ_W-1:0] v32;
      v32 = REQ_W'(v);
      if (v32 > REQ_W'(MAX_SEGMENT_BYTES)) begin
         return BYTE_W'(MAX_SEGMENT_BYTES);
      end
      return BYTE_W'(v32);
   endfunction

   back_state_type state_ff, state_in;

   logic [SEG_W-1:0]  newest_ff, newest_in;
   logic [SEG_W-1:0]  mark_seg_ff, mark_seg_in;
   logic [BYTE_W-1:0] mark_off_ff, mark_off_in;
   logic [BYTE_W-1:0] mark_rem_ff, mark_rem_in;
   logic [SEG_W-1:0]  pos_ff, pos_in;
   job_type           job_ff, job_in;
   logic [BYTE_W-1:0] cap_ff, cap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_load;

   logic              ram_we;
   logic [SEG_W-1:0]  ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [SEG_W-1:0]  ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   logic [BYTE_W-1:0] rd_off, rd_rem, req_low, small_cap, cap_sel;
   logic              start, fits, at_newest, exhausted, too_large;
   logic [7:0]        pos_wide;
   logic [REQ_W-1:0]  rd_off_wide;

   // each entry holds {next free offset, bytes remaining}
   mra_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_SEGMENTS)
   ) u_seg_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rd_off      = ram_rdata[WORD_W-1:BYTE_W];
   assign rd_rem      = ram_rdata[BYTE_W-1:0];
   assign req_low     = job_ff.req_bytes[BYTE_W-1:0];
   assign small_cap   = cap_bytes(cfg.small_bytes);
   assign cap_sel     = (8'(pos_ff) < 8'(cfg.big_from)) ? small_cap : cap_bytes(cfg.big_bytes);
   assign pos_wide    = 8'(pos_ff);
   assign rd_off_wide = REQ_W'(rd_off);

   assign start     = (state_ff == ST_IDLE) && job_valid && !rsp_valid_ff;
   assign fits      = REQ_W'(rd_rem) >= job_ff.req_bytes;
   assign at_newest = (pos_ff == newest_ff);
   assign exhausted = (newest_ff == LAST_SEG);
   assign too_large = job_ff.req_bytes > REQ_W'(MAX_SEGMENT_BYTES);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start && (job.mode == MODE_ALLOC || job.mode == MODE_SET_MARK)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (job_ff.mode != MODE_ALLOC || fits) begin
               state_in = ST_IDLE;
            end else if (!at_newest) begin
               state_in = ST_READ;
            end else if (exhausted || too_large) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_OPEN_SIZE;
            end
         end
         ST_OPEN_SIZE: begin
            state_in = ST_OPEN_WRITE;
         end
         ST_OPEN_WRITE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      job_take    = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = pos_ff;
      ram_wdata   = '0;
      ram_raddr   = pos_ff;
      rsp_load    = 1'b0;
      rsp_in      = '0;
      newest_in   = newest_ff;
      mark_seg_in = mark_seg_ff;
      mark_off_in = mark_off_ff;
      mark_rem_in = mark_rem_ff;
      pos_in      = pos_ff;
      job_in      = job_ff;
      cap_in      = cap_ff;
      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {BYTE_W'(0), INIT_REM};
         end
         ST_IDLE: begin
            if (start) begin
               job_take = 1'b1;
               job_in   = job;
               case (mode_type'(job.mode))
                  MODE_ALLOC: begin
                     pos_in = mark_seg_ff;
                  end
                  MODE_SET_MARK: begin
                     pos_in = newest_ff;
                  end
                  MODE_RELEASE: begin
                     ram_we    = 1'b1;
                     ram_waddr = mark_seg_ff;
                     ram_wdata = {mark_off_ff, mark_rem_ff};
                     newest_in = mark_seg_ff;
                     rsp_load  = 1'b1;
                  end
                  MODE_DROP_MARK: begin
                     mark_seg_in = '0;
                     mark_off_in = '0;
                     mark_rem_in = small_cap;
                     rsp_load    = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (job_ff.mode != MODE_ALLOC) begin
               mark_seg_in = newest_ff;
               mark_off_in = rd_off;
               mark_rem_in = rd_rem;
               rsp_load    = 1'b1;
            end else if (fits) begin
               ram_we            = 1'b1;
               ram_wdata         = {rd_off + req_low, rd_rem - req_low};
               rsp_load          = 1'b1;
               rsp_in.segment    = pos_wide[SEGMENT_W-1:0];
               rsp_in.offset     = rd_off_wide[OFFSET_W-1:0];
            end else if (!at_newest) begin
               pos_in = pos_ff + 1'b1;
            end else if (exhausted || too_large) begin
               // back to the empty arena
               ram_we        = 1'b1;
               ram_waddr     = '0;
               ram_wdata     = {BYTE_W'(0), small_cap};
               newest_in     = '0;
               mark_seg_in   = '0;
               mark_off_in   = '0;
               mark_rem_in   = small_cap;
               rsp_load      = 1'b1;
               rsp_in.status = exhausted ? STATUS_EXHAUSTED : STATUS_TOO_LARGE;
            end else begin
               pos_in = newest_ff + 1'b1;
            end
         end
         ST_OPEN_SIZE: begin
            // capacity never below the request
            cap_in = (REQ_W'(cap_sel) < job_ff.req_bytes) ? req_low : cap_sel;
         end
         ST_OPEN_WRITE: begin
            ram_we         = 1'b1;
            ram_wdata      = {req_low, cap_ff - req_low};
            newest_in      = pos_ff;
            rsp_load       = 1'b1;
            rsp_in.segment = pos_wide[SEGMENT_W-1:0];
         end
         default: begin
            job_take = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         newest_ff    <= '0;
         mark_seg_ff  <= '0;
         mark_off_ff  <= '0;
         mark_rem_ff  <= INIT_REM;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         newest_ff    <= newest_in;
         mark_seg_ff  <= mark_seg_in;
         mark_off_ff  <= mark_off_in;
         mark_rem_ff  <= mark_rem_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      job_ff <= job_in;
      cap_ff <= cap_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: tb/sv/mra_arena_checker.sv
// Checker for the arena allocator: tracks the channels, predicts each grant, compares results.
module mra_arena_checker
   import mra_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  req_type                req_data,
   input  logic                   empty,
   input  logic                   pop,
   input  rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending_count,
   output int                     checked_count,
   output int                     wipe_count
);

   localparam int NUM_SEGS  = MAX_SEGMENTS_DEFAULT;
   localparam longint unsigned SEG_LIMIT = MAX_SEGMENT_BYTES_DEFAULT;

   // register shadows
   logic [CAP_W-1:0]      cfg_small;
   logic [CAP_W-1:0]      cfg_big;
   logic [BIG_FROM_W-1:0] cfg_from;

   // arena shadow
   logic [OFFSET_W-1:0] free_off  [NUM_SEGS];
   logic [CAP_W-1:0]    room_left [NUM_SEGS];
   int unsigned         newest_seg;
   int unsigned         mark_seg;
   logic [OFFSET_W-1:0] mark_off;
   logic [CAP_W-1:0]    mark_room;

   rsp_type pending_grants[$];

   function automatic longint unsigned clamp_cap(input logic [CAP_W-1:0] v);
      return (longint'(v) > SEG_LIMIT) ? SEG_LIMIT : longint'(v);
   endfunction

   task automatic clear_arena();
      for (int i = 0; i < NUM_SEGS; i++) begin
         free_off[i]  = '0;
         room_left[i] = '0;
      end
      room_left[0] = CAP_W'(clamp_cap(cfg_small));
      newest_seg   = 0;
      mark_seg     = 0;
      mark_off     = '0;
      mark_room    = CAP_W'(clamp_cap(cfg_small));
   endtask

   task automatic predict_grant(input req_type item, output rsp_type grant);
      longint unsigned rounded;
      longint unsigned need;
      longint unsigned cap;
      int unsigned     pos;
      int unsigned     idx;
      bit              hit;
      grant        = '0;
      grant.status = STATUS_OK;
      case (item.mode)
         MODE_ALLOC: begin
            rounded = item.elem_bytes;
            if (rounded % ALIGN_BYTES != 0)
               rounded = rounded + ALIGN_BYTES - (rounded % ALIGN_BYTES);
            need = longint'(item.elem_count) * rounded;
            // first fit from the marked segment through the newest one
            hit = 1'b0;
            pos = mark_seg;
            while (!hit && pos <= newest_seg) begin
               if (longint'(room_left[pos]) >= need)
                  hit = 1'b1;
               else
                  pos++;
            end
            if (!hit) begin
               idx = newest_seg + 1;
               if (idx >= NUM_SEGS) begin
                  clear_arena();
                  grant.status = STATUS_EXHAUSTED;
               end else if (need > SEG_LIMIT) begin
                  clear_arena();
                  grant.status = STATUS_TOO_LARGE;
               end else begin
                  cap = (idx < cfg_from) ? clamp_cap(cfg_small) : clamp_cap(cfg_big);
                  if (cap < need) cap = need;
                  newest_seg     = idx;
                  free_off[idx]  = '0;
                  room_left[idx] = CAP_W'(cap);
                  pos            = idx;
                  hit            = 1'b1;
               end
            end
            if (hit) begin
               grant.segment  = SEGMENT_W'(pos);
               grant.offset   = free_off[pos];
               free_off[pos]  = OFFSET_W'(longint'(free_off[pos]) + need);
               room_left[pos] = CAP_W'(longint'(room_left[pos]) - need);
            end
         end
         MODE_SET_MARK: begin
            mark_seg  = newest_seg;
            mark_off  = free_off[newest_seg];
            mark_room = room_left[newest_seg];
         end
         MODE_RELEASE: begin
            for (int unsigned i = mark_seg + 1; i <= newest_seg && i < NUM_SEGS; i++) begin
               free_off[i]  = '0;
               room_left[i] = '0;
            end
            newest_seg          = mark_seg;
            free_off[mark_seg]  = mark_off;
            room_left[mark_seg] = mark_room;
         end
         default: begin
            mark_seg  = 0;
            mark_off  = '0;
            mark_room = CAP_W'(clamp_cap(cfg_small));
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      int      errs;
      int      seen;
      int      wipes;
      errs  = 0;
      seen  = 0;
      wipes = 0;
      if (reset) begin
         cfg_small = SMALL_BYTES_RESET;
         cfg_big   = BIG_BYTES_RESET;
         cfg_from  = BIG_FROM_RESET;
         clear_arena();
         pending_grants.delete();
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SMALL_BYTES: cfg_small = csr_data;
               CSR_BIG_BYTES:   cfg_big   = csr_data;
               CSR_BIG_FROM:    cfg_from  = csr_data[BIG_FROM_W-1:0];
               default: ;
            endcase
         end
         // results first: a grant never leaves on the edge its request enters
         if (pop && !empty) begin
            if (pending_grants.size() == 0) begin
               $error("result with nothing expected: segment %0d offset %0d status %0d",
                      rsp_data.segment, rsp_data.offset, rsp_data.status);
               errs++;
            end else begin
               want = pending_grants.pop_front();
               seen++;
               if (rsp_data.segment !== want.segment) begin
                  $error("segment: expected %0d, got %0d", want.segment, rsp_data.segment);
                  errs++;
               end
               if (rsp_data.offset !== want.offset) begin
                  $error("offset: expected %0d, got %0d", want.offset, rsp_data.offset);
                  errs++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errs++;
               end
            end
         end
         if (push && !full) begin
            predict_grant(req_data, want);
            pending_grants.push_back(want);
            if (want.status != STATUS_OK) wipes++;
         end
         pending_count <= pending_grants.size();
      end
      fail_count    <= fail_count + errs;
      checked_count <= checked_count + seen;
      wipe_count    <= wipe_count + wipes;
   end

endmodule

FILE: tb/sv/tb.sv
// Top of the arena allocator testbench: clock, reset, stimulus phases and the verdict.
module tb;
   import mra_pkg::*;

   // Worst serial run: ~950 transactions, each walking the segment table in the back end,
   // plus sender gaps and receiver stalls; the limit is set to cover that.
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 115;
   localparam int NUM_PHASES  = 8;
   // index 3 decodes to no register; a write there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   push      = 1'b0;
   logic                   full;
   req_type                req_data  = '0;
   logic                   empty;
   logic                   pop       = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SMALL_BYTES;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   int fail_count;
   int pending_count;
   int checked_count;
   int wipe_count;

   int idle_pct  = 0;   // chance per cycle that the sender holds off
   int stall_pct = 0;   // chance per cycle that the receiver refuses a result
   int sent_count = 0;
   int cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mark_release_arena_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   mra_arena_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .wipe_count    (wipe_count)
   );

   // Receiver: pop is redrawn every cycle, so stalls land on any state of the back end.
   always @(posedge clock)
      pop <= ($urandom_range(0, 99) >= stall_pct);

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic req_type make_req(input mode_type m, input int count, input int bytes);
      req_type r;
      r.mode       = m;
      r.elem_count = COUNT_W'(count);
      r.elem_bytes = ELEM_W'(bytes);
      return r;
   endfunction

   // Mostly allocations of modest size, so segments fill and open at a steady pace;
   // marks and releases interleave. A few full-range requests hit the oversize path.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      shape;
      pick         = $urandom_range(0, 99);
      shape        = $urandom_range(0, 99);
      r.elem_count = COUNT_W'($urandom);
      r.elem_bytes = ELEM_W'($urandom);
      if (pick < 8)
         r.mode = MODE_SET_MARK;
      else if (pick < 16)
         r.mode = MODE_RELEASE;
      else if (pick < 22)
         r.mode = MODE_DROP_MARK;
      else begin
         r.mode = MODE_ALLOC;
         if (shape < 6) begin
            // full range as drawn
         end else if (shape < 9)
            r.elem_count = '0;
         else if (shape < 12)
            r.elem_bytes = '0;
         else begin
            r.elem_count = COUNT_W'($urandom_range(1, 12));
            r.elem_bytes = ELEM_W'($urandom_range(1, 3000));
         end
      end
      return r;
   endfunction

   // Push one transaction. push is left high on return; the caller's next action
   // decides it, so it never gets two assignments in one step.
   task automatic send_req(input req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      sent_count++;
   endtask

   // Sender holds off until every outstanding grant has been popped.
   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CAP_W-1:0] s, input logic [CAP_W-1:0] b,
                             input logic [BIG_FROM_W-1:0] f, input bit poke_unused);
      csr_valid <= 1'b1;
      csr_index <= CSR_SMALL_BYTES;
      csr_data  <= s;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_BIG_BYTES;
      csr_data  <= b;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_BIG_FROM;
      csr_data  <= CSR_DATA_W'(f);
      do @(posedge clock); while (!csr_ready);
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_data  <= CSR_DATA_W'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0]      s_bytes;
      logic [CAP_W-1:0]      b_bytes;
      logic [BIG_FROM_W-1:0] b_from;
      bit                    poke;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset configuration, no idling.
      send_req(make_req(MODE_ALLOC, 0, 0));               // zero-byte request
      send_req(make_req(MODE_ALLOC, 1, 1));               // rounds up to 4
      send_req(make_req(MODE_ALLOC, 3, 5));
      send_req(make_req(MODE_ALLOC, 65535, 65535));       // oversize, arena wiped
      send_req(make_req(MODE_ALLOC, 0, 65535));           // zero count
      send_req(make_req(MODE_SET_MARK, 65535, 65535));    // fields ignored
      send_req(make_req(MODE_ALLOC, 2, 65535));
      send_req(make_req(MODE_RELEASE, 0, 0));
      send_req(make_req(MODE_DROP_MARK, 65535, 0));
      send_req(make_req(MODE_RELEASE, 0, 65535));         // back to segment 0 start
      // new segment raised to request size
      send_req(make_req(MODE_ALLOC, 65535, 256));
      // 1 MB each: every request opens a segment until the table runs out
      for (int i = 0; i < 15; i++)
         send_req(make_req(MODE_ALLOC, 16, 65533));
      wait_drained();

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         poke = 1'b0;
         case (phase)
            1: begin s_bytes = 1;        b_bytes = 1;        b_from = 0;  end
            2: begin s_bytes = 16777216; b_bytes = '1;       b_from = 16; end
            3: begin s_bytes = 4096;     b_bytes = 65536;    b_from = 4;  end
            4: begin s_bytes = 0;        b_bytes = 256;      b_from = '1; end
            6: begin s_bytes = '1;       b_bytes = 1024;     b_from = 1;  poke = 1'b1; end
            8: begin s_bytes = SMALL_BYTES_RESET; b_bytes = BIG_BYTES_RESET;
                     b_from = BIG_FROM_RESET; end
            default: begin
               s_bytes = CAP_W'($urandom_range(1, 1 << 20));
               b_bytes = CAP_W'($urandom_range(1, 1 << 22));
               b_from  = BIG_FROM_W'($urandom_range(0, 16));
               poke    = 1'b1;
            end
         endcase
         // idle between phases: wait_drained has run, so the back end is empty
         write_regs(s_bytes, b_bytes, b_from, poke);

         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_req(random_request());
            if ($urandom_range(0, 59) == 0) wait_drained();
         end
         wait_drained();
      end

      // tail: look for stray results after the last grant
      idle_pct  = 0;
      stall_pct = 0;
      repeat (60) @(posedge clock);

      if (pending_count != 0)
         $error("%0d results never arrived", pending_count);
      $display("Covered %0d requests over %0d configuration phases plus a directed set;",
               sent_count, NUM_PHASES);
      $display("%0d results checked, %0d of them wiped the arena.", checked_count, wipe_count);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
sv/mra_pkg.sv
sv/mra_ram.sv
sv/mra_front.sv
sv/mra_back.sv
sv/mark_release_arena_allocator_core.sv
tb/sv/mra_arena_checker.sv
tb/sv/tb.sv
